>>> design/mid_pkg.sv
`timescale 1ns / 1ps

package mid_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_AXES        = 3;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int LEN_RESET       = 65536;
    localparam logic [NUM_AXES-1:0] MASK_RESET = 3'b111;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_LENGTH_X      = 2'd0,
        CFG_LENGTH_Y      = 2'd1,
        CFG_LENGTH_Z      = 2'd2,
        CFG_PERIODIC_MASK = 2'd3
    } t_cfg_reg;

endpackage

>>> design/mid_delta_if.sv
`timescale 1ns / 1ps

interface mid_delta_if
    import mid_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] delta_x;
    logic signed [COORD_WIDTH-1:0] delta_y;
    logic signed [COORD_WIDTH-1:0] delta_z;

    modport source (output valid, output delta_x, output delta_y, output delta_z,
                    input ready);
    modport sink   (input valid, input delta_x, input delta_y, input delta_z,
                    output ready);
endinterface

>>> design/mid_image_if.sv
`timescale 1ns / 1ps

interface mid_image_if
    import mid_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] image_x;
    logic signed [COORD_WIDTH-1:0] image_y;
    logic signed [COORD_WIDTH-1:0] image_z;

    modport source (output valid, output image_x, output image_y, output image_z,
                    input ready);
    modport sink   (input valid, input image_x, input image_y, input image_z,
                    output ready);
endinterface

>>> design/mid_cfg_if.sv
`timescale 1ns / 1ps

interface mid_cfg_if
    import mid_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [COORD_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/minimum_image_displacement_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Word
// i_delta   in         delta_x, delta_y, delta_z (signed, COORD_WIDTH bits)
// o_image   out        image_x, image_y, image_z (signed, COORD_WIDTH bits)
// i_cfg     in         register index and write data, always ready
//
// One word enters per cycle while the pipeline is not held (see below).
// The remainder pipeline takes one restoring step per bit of magnitude.
// Reset is synchronous and active low; it clears the valid bits and loads the config registers.
// When the output word is not taken, the whole pipeline holds, unless the output is empty.

module minimum_image_displacement_core
    import mid_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mid_delta_if.sink      i_delta,
    mid_image_if.source    o_image,
    mid_cfg_if.sink        i_cfg
);

    localparam int LW = COORD_WIDTH - 1;
    localparam int NS = COORD_WIDTH;
    localparam int LAST = NS + 1;

    logic [LW-1:0]       r_len  [NUM_AXES];
    logic [NUM_AXES-1:0] r_mask;

    logic [LAST:0] r_valid;
    logic [LAST:0] n_valid;

    logic [LW-1:0]          r_rem  [NUM_AXES][NS+1];
    logic [COORD_WIDTH-1:0] r_mag  [NUM_AXES][NS+1];
    logic [COORD_WIDTH-1:0] r_raw  [NUM_AXES][NS+1];
    logic                   r_neg  [NUM_AXES][NS+1];
    logic                   r_pass [NUM_AXES][NS+1];
    logic [LW-1:0]          n_rem  [NUM_AXES][NS+1];
    logic [COORD_WIDTH-1:0] n_mag  [NUM_AXES][NS+1];
    logic [COORD_WIDTH-1:0] n_raw  [NUM_AXES][NS+1];
    logic                   n_neg  [NUM_AXES][NS+1];
    logic                   n_pass [NUM_AXES][NS+1];

    logic [COORD_WIDTH-1:0] r_out [NUM_AXES];
    logic [COORD_WIDTH-1:0] n_out [NUM_AXES];

    logic                   advance;
    logic [COORD_WIDTH-1:0] in_word [NUM_AXES];

    assign advance = !r_valid[LAST] || o_image.ready;
    assign i_delta.ready = advance;
    assign i_cfg.ready = 1'b1;

    assign in_word[0] = i_delta.delta_x;
    assign in_word[1] = i_delta.delta_y;
    assign in_word[2] = i_delta.delta_z;

    assign o_image.valid   = r_valid[LAST];
    assign o_image.image_x = r_out[0];
    assign o_image.image_y = r_out[1];
    assign o_image.image_z = r_out[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_len[a] <= LW'(LEN_RESET);
            end
            r_mask <= MASK_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_LENGTH_X:      r_len[0] <= i_cfg.data[LW-1:0];
                CFG_LENGTH_Y:      r_len[1] <= i_cfg.data[LW-1:0];
                CFG_LENGTH_Z:      r_len[2] <= i_cfg.data[LW-1:0];
                CFG_PERIODIC_MASK: r_mask   <= i_cfg.data[NUM_AXES-1:0];
            endcase
        end
    end

    always_comb begin
        logic [COORD_WIDTH-1:0] v;
        logic [COORD_WIDTH-1:0] mag;
        logic [COORD_WIDTH-1:0] len_ext;
        logic [COORD_WIDTH-1:0] half_ext;
        logic [COORD_WIDTH-1:0] trial;
        logic [COORD_WIDTH-1:0] fold;
        logic [COORD_WIDTH-1:0] sgn;
        n_valid = {r_valid[LAST-1:0], i_delta.valid};
        for (int a = 0; a < NUM_AXES; a++) begin
            len_ext  = {1'b0, r_len[a]};
            half_ext = len_ext >> 1;

            v   = in_word[a];
            mag = v[COORD_WIDTH-1] ? (~v + 1'b1) : v;
            n_raw[a][0]  = v;
            n_neg[a][0]  = v[COORD_WIDTH-1];
            n_mag[a][0]  = mag;
            n_rem[a][0]  = '0;
            n_pass[a][0] = !r_mask[a] || (r_len[a] == '0);

            for (int s = 1; s <= NS; s++) begin
                trial = {r_rem[a][s-1], r_mag[a][s-1][COORD_WIDTH-1]};
                if (trial >= len_ext) begin
                    trial = trial - len_ext;
                end
                n_rem[a][s]  = trial[LW-1:0];
                n_mag[a][s]  = {r_mag[a][s-1][COORD_WIDTH-2:0], 1'b0};
                n_raw[a][s]  = r_raw[a][s-1];
                n_neg[a][s]  = r_neg[a][s-1];
                if (s == 1) begin
                    n_pass[a][s] = r_pass[a][s-1] || (r_mag[a][s-1] <= half_ext);
                end else begin
                    n_pass[a][s] = r_pass[a][s-1];
                end
            end

            fold = {1'b0, r_rem[a][NS]};
            if (fold > half_ext) begin
                sgn = r_neg[a][NS] ? (len_ext - fold) : (fold - len_ext);
            end else begin
                sgn = r_neg[a][NS] ? (~fold + 1'b1) : fold;
            end
            n_out[a] = r_pass[a][NS] ? r_raw[a][NS] : sgn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int s = 0; s <= NS; s++) begin
                    r_rem[a][s]  <= n_rem[a][s];
                    r_mag[a][s]  <= n_mag[a][s];
                    r_raw[a][s]  <= n_raw[a][s];
                    r_neg[a][s]  <= n_neg[a][s];
                    r_pass[a][s] <= n_pass[a][s];
                end
                r_out[a] <= n_out[a];
            end
        end
    end

    logic [COORD_WIDTH:0]   chk_mag [NUM_AXES];
    logic [COORD_WIDTH+1:0] chk_len [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            chk_mag[a] = r_out[a][COORD_WIDTH-1]
                ? ({1'b0, ~r_out[a]} + 1'b1) : {1'b0, r_out[a]};
            chk_len[a] = (COORD_WIDTH + 2)'(r_len[a]);
        end
    end

    generate
        for (genvar a = 0; a < NUM_AXES; a++) begin : g_chk
            a_folded_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_valid[LAST] && r_mask[a] && (r_len[a] != '0))
                |-> ({chk_mag[a], 1'b0} <= chk_len[a]))
                else $error("folded component outside half box length");

            a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_valid[NS] && !r_pass[a][NS]) |-> (r_rem[a][NS] < r_len[a]))
                else $error("remainder not below box length");
        end
    endgenerate

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_valid))
        else $error("pipeline valid bits moved during a stall");

    a_ready_only_blocked_by_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_delta.ready |-> (o_image.valid && !o_image.ready))
        else $error("input blocked without a waiting output word");

endmodule

>>> verif/minimum_image_displacement_core_tb.sv
`timescale 1ns / 1ps

module minimum_image_displacement_core_tb
    import mid_pkg::*;
;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int PIPE_LATENCY = CW + 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 188;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } t_image_word;

    logic i_clk;
    logic i_rst_n;

    mid_delta_if #(.COORD_WIDTH(CW)) delta_bus ();
    mid_image_if #(.COORD_WIDTH(CW)) image_bus ();
    mid_cfg_if   #(.COORD_WIDTH(CW)) cfg_bus ();

    minimum_image_displacement_core #(.COORD_WIDTH(CW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_delta (delta_bus),
        .o_image (image_bus),
        .i_cfg   (cfg_bus)
    );

    logic [CW-2:0] box_len_x;
    logic [CW-2:0] box_len_y;
    logic [CW-2:0] box_len_z;
    logic [2:0]    axis_periodic;

    t_image_word pending_images[$];
    int          mismatch_count;
    int          idle_cycles;
    int          burst_left;
    int          ready_run;
    int          ready_stall;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [CW-1:0] fold_component(input logic [CW-1:0] raw,
                                                     input logic [CW-2:0] len,
                                                     input bit periodic);
        logic [63:0] coord_mask;
        logic [63:0] value;
        logic [63:0] span;
        logic [63:0] half;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [63:0] folded;
        coord_mask = (64'd1 << CW) - 64'd1;
        value = 64'(raw);
        span  = 64'(len);
        if (!periodic || span == 64'd0) begin
            return raw;
        end
        half = span >> 1;
        mag  = raw[CW-1] ? ((64'd0 - value) & coord_mask) : value;
        if (mag <= half) begin
            return raw;
        end
        rem    = mag % span;
        folded = (rem > half) ? (rem - span) : rem;
        if (raw[CW-1]) begin
            folded = 64'd0 - folded;
        end
        return folded[CW-1:0];
    endfunction

    function automatic t_image_word predict_image(input logic [CW-1:0] dx,
                                                  input logic [CW-1:0] dy,
                                                  input logic [CW-1:0] dz);
        t_image_word word;
        word.x = fold_component(dx, box_len_x, axis_periodic[0]);
        word.y = fold_component(dy, box_len_y, axis_periodic[1]);
        word.z = fold_component(dz, box_len_z, axis_periodic[2]);
        return word;
    endfunction

    function automatic logic [CW-1:0] pick_component(input logic [CW-2:0] len);
        longint      span;
        longint      k;
        longint      v;
        int unsigned reach;
        span = (len == '0) ? 64'sd65536 : longint'(len);
        k    = longint'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                reach = int'(span + 2);
                v = k * span + longint'($urandom_range(0, reach)) - span / 2 - 1;
            end
            4: begin
                v = k * span + (($urandom_range(0, 1) == 1) ? span / 2 : -(span / 2));
            end
            5, 6: begin
                v = longint'($urandom);
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: v = 64'sh7FFF_FFFF;
                    1: v = -64'sh8000_0000;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            default: begin
                v = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
            end
        endcase
        return v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CW'($urandom_range(1, 4));
            2: return CW'(32'h7FFF_FFFF);
            3, 4: return CW'($urandom_range(1, 64) << 16);
            5, 6: return CW'($urandom_range(32'h8000, 32'h40_0000));
            7: return CW'($urandom);
            8: return CW'($urandom_range(1, 32'h7FFF_FFFF));
            default: return CW'(LEN_RESET);
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_image_word got;
        t_image_word want;
        logic        moved;
        if (!i_rst_n) begin
            box_len_x     = (CW-1)'(LEN_RESET);
            box_len_y     = (CW-1)'(LEN_RESET);
            box_len_z     = (CW-1)'(LEN_RESET);
            axis_periodic = MASK_RESET;
            idle_cycles   = 0;
        end else begin
            moved = 1'b0;
            if (image_bus.valid && image_bus.ready) begin
                moved = 1'b1;
                got.x = image_bus.image_x;
                got.y = image_bus.image_y;
                got.z = image_bus.image_z;
                if (pending_images.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected image word at %0t: x=%h y=%h z=%h",
                                 $time, got.x, got.y, got.z);
                    end
                end else begin
                    want = pending_images.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"image mismatch at %0t: expected x=%h y=%h z=%h,",
                                      " got x=%h y=%h z=%h"},
                                     $time, want.x, want.y, want.z, got.x, got.y, got.z);
                        end
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                case (t_cfg_reg'(cfg_bus.index))
                    CFG_LENGTH_X:      box_len_x     = cfg_bus.data[CW-2:0];
                    CFG_LENGTH_Y:      box_len_y     = cfg_bus.data[CW-2:0];
                    CFG_LENGTH_Z:      box_len_z     = cfg_bus.data[CW-2:0];
                    CFG_PERIODIC_MASK: axis_periodic = cfg_bus.data[2:0];
                    default: ;
                endcase
            end
            if (delta_bus.valid && delta_bus.ready) begin
                moved = 1'b1;
                pending_images.push_back(predict_image(delta_bus.delta_x, delta_bus.delta_y,
                                                       delta_bus.delta_z));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (ready_run > 0) begin
            image_bus.ready <= 1'b1;
            ready_run--;
        end else if (ready_stall > 0) begin
            image_bus.ready <= 1'b0;
            ready_stall--;
        end else begin
            ready_run   = $urandom_range(0, 40);
            ready_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            image_bus.ready <= 1'b1;
        end
    end

    task automatic send_displacement(input logic [CW-1:0] dx, input logic [CW-1:0] dy,
                                     input logic [CW-1:0] dz);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                delta_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        delta_bus.valid   <= 1'b1;
        delta_bus.delta_x <= dx;
        delta_bus.delta_y <= dy;
        delta_bus.delta_z <= dz;
        do @(posedge i_clk); while (!delta_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        delta_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_images.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CW-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CW-1:0] len_x, input logic [CW-1:0] len_y,
                             input logic [CW-1:0] len_z, input logic [CW-1:0] mask);
        wait_for_results();
        write_register(CFG_LENGTH_X, len_x);
        write_register(CFG_LENGTH_Y, len_y);
        write_register(CFG_LENGTH_Z, len_z);
        write_register(CFG_PERIODIC_MASK, mask);
        cfg_bus.valid <= 1'b0;
    endtask

    // With the reset box length of 65536 per axis: halves, whole lengths and the range ends.
    task automatic test_reset_defaults();
        send_displacement(32'd0, 32'd32768, -32'sd32768);
        send_displacement(32'd32769, -32'sd32769, 32'd65536);
        send_displacement(-32'sd65536, 32'd98304, -32'sd98304);
        send_displacement(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_displacement(32'd1, 32'h0001_0001, 32'hFFFE_FFFF);
        send_displacement(32'h7FFF_8000, 32'h8000_8000, 32'h1234_5678);
    endtask

    // Zero lengths, dropped high bits of writes, lengths of one and two, and masked axes.
    task automatic test_register_extremes();
        configure(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFA);
        send_displacement(32'h7FFF_FFFF, 32'h8000_0000, 32'd5);
        send_displacement(32'h4000_0000, 32'h4000_0000, -32'sd3);
        send_displacement(32'hC000_0000, 32'hC000_0001, 32'h3FFF_FFFF);
        configure(32'd65536, 32'd0, 32'd1, 32'd7);
        send_displacement(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_displacement(32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF);
        send_displacement(32'h0003_0001, -32'sd7, 32'd2);
        configure(32'h8000_0003, 32'd2, 32'h7FFF_FFFF, 32'h0000_0005);
        send_displacement(32'h8000_0000, 32'd1, 32'h8000_0000);
        send_displacement(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_displacement(32'd4, 32'd5, 32'hBFFF_FFFF);
        send_displacement(-32'sd2, -32'sd3, 32'h4000_0000);
        configure(32'd65536, 32'd65536, 32'd65536, 32'd0);
        send_displacement(32'h0005_8000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_displacement(32'hFFFA_8000, 32'd32769, -32'sd98304);
    endtask

    task automatic test_random_phases();
        logic [CW-1:0] mask_word;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd7);
            end else begin
                mask_word = CW'($urandom);
                mask_word[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
                configure(pick_length(), pick_length(), pick_length(), mask_word);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_results();
                end
                send_displacement(pick_component(box_len_x), pick_component(box_len_y),
                                  pick_component(box_len_z));
            end
        end
    endtask

    task automatic finish_run();
        wait_for_results();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_images.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        delta_bus.valid   = 1'b0;
        delta_bus.delta_x = '0;
        delta_bus.delta_y = '0;
        delta_bus.delta_z = '0;
        image_bus.ready   = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_LENGTH_X;
        cfg_bus.data      = '0;
        mismatch_count    = 0;
        idle_cycles       = 0;
        burst_left        = 0;
        ready_run         = 0;
        ready_stall       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        finish_run();
    end

endmodule
